// ===== hdl/abrf_pkg.sv =====
package abrf_pkg;

    // operation codes of one transaction
    typedef enum logic [2:0] {
        OP_READ_REG   = 3'd0,
        OP_WRITE_REG  = 3'd1,
        OP_READ_CPSR  = 3'd2,
        OP_WRITE_CPSR = 3'd3,
        OP_READ_SPSR  = 3'd4,
        OP_WRITE_SPSR = 3'd5,
        OP_IRQ_CHECK  = 3'd6,
        OP_SET_HALT   = 3'd7
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_IRQ_PC,
        ST_IRQ_SPSR
    } state_t;

    // arm mode codes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1b;
    localparam logic [4:0] MODE_SYS = 5'h1f;

    // shadow bank numbers
    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    // cpsr bits
    localparam int BIT_T = 5;
    localparam int BIT_I = 7;
    localparam logic [31:0] CPSR_RESET  = 32'h0000_00d3;
    localparam logic [31:0] IRQ_VEC_OFS = 32'h0000_0018;
    localparam logic [31:0] PC_OFS_ARM  = 32'd8;
    localparam logic [31:0] PC_OFS_THB  = 32'd4;
    localparam logic [31:0] LR_IRQ_ADJ  = 32'd4;

    // register storage layout: main regs, shadow banks, saved status
    localparam int          MEM_DEPTH     = 64;
    localparam int          ADDR_W        = 6;
    localparam int          BANK_REGS     = 7;
    localparam logic [5:0]  SHADOW_BASE   = 6'd16;
    localparam logic [5:0]  SPSR_BASE     = 6'd58;
    localparam logic [5:0]  PC_ADDR       = 6'd15;
    localparam logic [5:0]  IRQ_LR_ADDR   = 6'd36;
    localparam logic [5:0]  SPSR_IRQ_ADDR = 6'd60;

    // configuration register index (paddr bit 2)
    localparam logic CFG_IDX_EXC_BASE = 1'b0;

    // storage access from the sequencer
    typedef struct packed {
        logic        re;
        logic [5:0]  raddr;
        logic        we;
        logic [5:0]  waddr;
        logic [31:0] wdata;
    } mem_req_t;

    function automatic logic [2:0] bank_of(input logic [4:0] mode);
        logic [2:0] bank;
        case (mode)
            MODE_FIQ: bank = BANK_FIQ;
            MODE_IRQ: bank = BANK_IRQ;
            MODE_SVC: bank = BANK_SVC;
            MODE_ABT: bank = BANK_ABT;
            MODE_UND: bank = BANK_UND;
            default:  bank = BANK_USR;
        endcase
        return bank;
    endfunction

    function automatic logic [5:0] slot_addr(input logic [3:0] r, input logic [4:0] mode);
        logic       banked;
        logic [5:0] addr;
        if (mode == MODE_FIQ)
            banked = (r >= 4'd8) && (r <= 4'd14);
        else
            banked = (r >= 4'd13) && (r <= 4'd14) && (mode != MODE_USR) && (mode != MODE_SYS);
        if (banked)
            addr = SHADOW_BASE + ({3'b000, bank_of(mode)} * 6'(BANK_REGS))
                   + ({2'b00, r} - 6'd8);
        else
            addr = {2'b00, r};
        return addr;
    endfunction

    function automatic logic [5:0] spsr_addr(input logic [4:0] mode);
        return SPSR_BASE + {3'b000, bank_of(mode)};
    endfunction

endpackage

// ===== hdl/abrf_mem.sv =====
module abrf_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  abrf_pkg::mem_req_t req,
    output logic [31:0]        rdata
);
    import abrf_pkg::*;

    logic [31:0]          mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [31:0]          rdata_reg;
    logic                 rvalid_reg;

    // storage array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        if (req.re)
            rdata_reg <= mem[req.raddr];
    end

    // written flags, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
                valid_reg[req.waddr] <= 1'b1;
            if (req.re)
                rvalid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

// ===== hdl/abrf_ctrl.sv =====
module abrf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic [3:0]         reg_index,
    input  logic               use_current_mode,
    input  logic [4:0]         access_mode,
    input  logic [31:0]        write_data,
    input  logic               irq_line,
    input  logic               halt_value,
    input  logic [31:0]        exception_base,
    output abrf_pkg::mem_req_t mem_req,
    input  logic [31:0]        mem_rdata,
    output logic               done,
    output logic [31:0]        read_data,
    output logic               interrupt_taken,
    output logic               halted_now,
    output logic [4:0]         mode_now
);
    import abrf_pkg::*;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [5:0]  addr_reg, addr_next;
    logic [31:0] data_reg, data_next;
    logic        irq_reg, irq_next;
    logic        halt_val_reg, halt_val_next;
    logic [31:0] cpsr_reg, cpsr_next;
    logic        halted_reg, halted_next;
    logic [31:0] spsr_save_reg, spsr_save_next;
    logic        done_reg, done_next;
    logic [31:0] read_data_reg, read_data_next;
    logic        taken_reg, taken_next;

    logic        accept;
    logic        irq_take;
    logic [4:0]  mode_in;
    logic [5:0]  addr_in;
    logic [31:0] pc_ofs;

    assign accept   = start && (state_reg == ST_IDLE);
    assign irq_take = (op_reg == OP_IRQ_CHECK) && irq_reg && !cpsr_reg[BIT_I];
    assign mode_in  = use_current_mode ? cpsr_reg[4:0] : access_mode;
    assign pc_ofs   = cpsr_reg[BIT_T] ? PC_OFS_THB : PC_OFS_ARM;

    // storage address of the incoming transaction
    always_comb
    begin
        case (op_t'(operation)) inside
            OP_READ_SPSR, OP_WRITE_SPSR: addr_in = spsr_addr(mode_in);
            OP_IRQ_CHECK:                addr_in = PC_ADDR;
            default:                     addr_in = slot_addr(reg_index, mode_in);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_EXEC;
            ST_EXEC:     state_next = irq_take ? ST_IRQ_PC : ST_IDLE;
            ST_IRQ_PC:   state_next = ST_IRQ_SPSR;
            ST_IRQ_SPSR: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and storage access per state
    always_comb
    begin
        op_next        = op_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        irq_next       = irq_reg;
        halt_val_next  = halt_val_reg;
        cpsr_next      = cpsr_reg;
        halted_next    = halted_reg;
        spsr_save_next = spsr_save_reg;
        done_next      = 1'b0;
        read_data_next = 32'd0;
        taken_next     = 1'b0;
        mem_req.re     = 1'b0;
        mem_req.raddr  = addr_in;
        mem_req.we     = 1'b0;
        mem_req.waddr  = addr_reg;
        mem_req.wdata  = data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = op_t'(operation);
                    addr_next     = addr_in;
                    data_next     = write_data;
                    irq_next      = irq_line;
                    halt_val_next = halt_value;
                    mem_req.re    = 1'b1;
                end
            end
            ST_EXEC:
            begin
                done_next = !irq_take;
                case (op_reg)
                    OP_READ_REG, OP_READ_SPSR: read_data_next = mem_rdata;
                    OP_WRITE_REG:
                    begin
                        mem_req.we = 1'b1;
                        if (addr_reg == PC_ADDR)
                            mem_req.wdata = data_reg + pc_ofs;
                    end
                    OP_READ_CPSR:  read_data_next = cpsr_reg;
                    OP_WRITE_CPSR: cpsr_next = data_reg;
                    OP_WRITE_SPSR: mem_req.we = 1'b1;
                    OP_IRQ_CHECK:
                    begin
                        if (irq_take)
                        begin
                            // irq entry: lr, new mode, then pc and spsr in later cycles
                            mem_req.we     = 1'b1;
                            mem_req.waddr  = IRQ_LR_ADDR;
                            mem_req.wdata  = cpsr_reg[BIT_T] ? mem_rdata : mem_rdata - LR_IRQ_ADJ;
                            cpsr_next      = {cpsr_reg[31:8], 1'b1, cpsr_reg[6], 1'b0, MODE_IRQ};
                            halted_next    = 1'b0;
                            spsr_save_next = cpsr_reg;
                        end
                    end
                    OP_SET_HALT:   halted_next = halt_val_reg;
                    default:       read_data_next = 32'd0;
                endcase
            end
            ST_IRQ_PC:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = PC_ADDR;
                mem_req.wdata = exception_base + IRQ_VEC_OFS + PC_OFS_ARM;
            end
            ST_IRQ_SPSR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = SPSR_IRQ_ADDR;
                mem_req.wdata = spsr_save_reg;
                done_next     = 1'b1;
                taken_next    = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_READ_REG;
            addr_reg      <= '0;
            data_reg      <= '0;
            irq_reg       <= 1'b0;
            halt_val_reg  <= 1'b0;
            cpsr_reg      <= CPSR_RESET;
            halted_reg    <= 1'b0;
            spsr_save_reg <= '0;
            done_reg      <= 1'b0;
            read_data_reg <= '0;
            taken_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            irq_reg       <= irq_next;
            halt_val_reg  <= halt_val_next;
            cpsr_reg      <= cpsr_next;
            halted_reg    <= halted_next;
            spsr_save_reg <= spsr_save_next;
            done_reg      <= done_next;
            read_data_reg <= read_data_next;
            taken_reg     <= taken_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign read_data       = read_data_reg;
    assign interrupt_taken = taken_reg;
    assign halted_now      = halted_reg;
    assign mode_now        = cpsr_reg[4:0];

`ifndef SYNTHESIS
    // an accepted transaction is executed in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    // interrupt entry leaves irq mode with the core running
    a_taken_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && interrupt_taken) |-> ((mode_now == MODE_IRQ) && !halted_now
                                       && cpsr_reg[BIT_I] && !cpsr_reg[BIT_T]))
        else $error("interrupt entry left wrong status");

    // storage is never written while idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_req.we)
        else $error("storage write while idle");

    // a result strobe follows the last step of a transaction
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_IRQ_SPSR))
        else $error("result strobe without finished transaction");
`endif

endmodule

// ===== hdl/arm_banked_register_file.sv =====
// Mode-banked register file of an ARMv4/v5 core.
// Command channel: a transaction is accepted at a rising edge with start high
// and busy low; its operation, register number, mode selection, write data,
// irq level and halt value are sampled at that edge.
// Result channel: done is high for exactly one cycle with read_data,
// interrupt_taken, halted_now and mode_now; the receiver cannot stall it.
// Sequence: an accepted transaction enters the execute state, and done is
// registered from it; busy is high for one cycle unless an irq entry is taken,
// and the next may be accepted in the same cycle that done is shown.
// An irq check that enters irq mode also passes the pc and saved-status states:
// the single write port of the register storage writes lr, pc and the saved status one after another.
// Every transaction reads the storage once at acceptance.
// Configuration: APB write of exception_base at byte address 0, only while
// no transaction is in flight; pready is always high.
// Reset: cpsr becomes svc mode with irq and fiq masked, all registers, saved
// status, halted flag and exception_base read as zero.
module arm_banked_register_file (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [3:0]  reg_index,
    input  logic        use_current_mode,
    input  logic [4:0]  access_mode,
    input  logic [31:0] write_data,
    input  logic        irq_line,
    input  logic        halt_value,
    output logic        done,
    output logic [31:0] read_data,
    output logic        interrupt_taken,
    output logic        halted_now,
    output logic [4:0]  mode_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import abrf_pkg::*;

    logic [31:0] exc_base_reg;
    logic        cfg_write;
    mem_req_t    mem_req;
    logic [31:0] mem_rdata;

    // apb configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exc_base_reg <= '0;
        else if (cfg_write && (paddr[2] == CFG_IDX_EXC_BASE))
            exc_base_reg <= pwdata;
    end

    assign prdata = (paddr[2] == CFG_IDX_EXC_BASE) ? exc_base_reg : 32'd0;

    // register storage
    abrf_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // transaction sequencer and status registers
    abrf_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .reg_index        (reg_index),
        .use_current_mode (use_current_mode),
        .access_mode      (access_mode),
        .write_data       (write_data),
        .irq_line         (irq_line),
        .halt_value       (halt_value),
        .exception_base   (exc_base_reg),
        .mem_req          (mem_req),
        .mem_rdata        (mem_rdata),
        .done             (done),
        .read_data        (read_data),
        .interrupt_taken  (interrupt_taken),
        .halted_now       (halted_now),
        .mode_now         (mode_now)
    );

endmodule

// ===== dv/tb_arm_banked_register_file.sv =====
module tb_arm_banked_register_file;

    import abrf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;

    // one expected result transaction
    typedef struct {
        logic [31:0] rd;
        logic        taken;
        logic        halted;
        logic [4:0]  mode;
    } outcome_t;

    // banked register file state and the queue of expected results
    class regfile_scoreboard;
        logic [31:0] regs [58];    // 0..15 main, 16..57 shadow banks of seven
        logic [31:0] spsr [6];
        logic [31:0] cpsr;
        logic        halted;
        logic [31:0] vector_base;
        outcome_t    awaited [$];
        int          mismatches;
        int          commands;
        int          irq_entries;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (spsr[i]) spsr[i] = '0;
            cpsr        = CPSR_RESET;
            halted      = 1'b0;
            vector_base = '0;
            mismatches  = 0;
            commands    = 0;
            irq_entries = 0;
        endfunction

        function int bank_index(logic [4:0] mode);
            case (mode)
                MODE_FIQ: return BANK_FIQ;
                MODE_IRQ: return BANK_IRQ;
                MODE_SVC: return BANK_SVC;
                MODE_ABT: return BANK_ABT;
                MODE_UND: return BANK_UND;
                default:  return BANK_USR;
            endcase
        endfunction

        // fiq banks r8..r14, other privileged and unknown modes bank r13..r14
        function int reg_location(logic [3:0] r, logic [4:0] mode);
            logic banked;
            if (mode == MODE_USR || mode == MODE_SYS || r == 4'd15)
                banked = 1'b0;
            else if (mode == MODE_FIQ)
                banked = (r >= 4'd8);
            else
                banked = (r >= 4'd13);
            if (banked)
                return 16 + bank_index(mode) * 7 + (int'(r) - 8);
            return int'(r);
        endfunction

        // pc writes ignore the mode and add the pipeline offset
        function void store_reg(logic [3:0] r, logic [4:0] mode, logic [31:0] value);
            if (r == 4'd15)
                regs[15] = value + (cpsr[BIT_T] ? PC_OFS_THB : PC_OFS_ARM);
            else
                regs[reg_location(r, mode)] = value;
        endfunction

        function void note_command(op_t op, logic [3:0] r, logic own_mode,
                                   logic [4:0] named_mode, logic [31:0] data,
                                   logic irq, logic halt);
            logic [4:0]  mode;
            logic [31:0] pc;
            outcome_t    res;
            mode      = own_mode ? cpsr[4:0] : named_mode;
            res.rd    = '0;
            res.taken = 1'b0;
            case (op)
                OP_READ_REG:   res.rd = regs[reg_location(r, mode)];
                OP_WRITE_REG:  store_reg(r, mode, data);
                OP_READ_CPSR:  res.rd = cpsr;
                OP_WRITE_CPSR: cpsr = data;
                OP_READ_SPSR:  res.rd = spsr[bank_index(mode)];
                OP_WRITE_SPSR: spsr[bank_index(mode)] = data;
                OP_IRQ_CHECK:
                    if (irq && !cpsr[BIT_I])
                    begin
                        pc             = regs[15];
                        halted         = 1'b0;
                        spsr[BANK_IRQ] = cpsr;
                        cpsr           = {cpsr[31:5], MODE_IRQ};
                        cpsr[BIT_I]    = 1'b1;
                        // thumb state returns to pc, arm state to pc - 4
                        if (cpsr[BIT_T])
                        begin
                            cpsr[BIT_T] = 1'b0;
                            store_reg(4'd14, MODE_IRQ, pc);
                        end
                        else
                        begin
                            store_reg(4'd14, MODE_IRQ, pc - LR_IRQ_ADJ);
                        end
                        store_reg(4'd15, MODE_IRQ, vector_base + IRQ_VEC_OFS);
                        res.taken = 1'b1;
                        irq_entries++;
                    end
                default:       halted = halt;
            endcase
            res.halted = halted;
            res.mode   = cpsr[4:0];
            awaited.push_back(res);
            commands++;
        endfunction

        function void check_result(logic [31:0] rd, logic taken, logic hlt,
                                   logic [4:0] mode);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_data=%h taken=%b halted=%b mode=%h",
                             rd, taken, hlt, mode);
                return;
            end
            want = awaited.pop_front();
            if (want.rd !== rd || want.taken !== taken || want.halted !== hlt
                || want.mode !== mode)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp: read_data=%h taken=%b halted=%b mode=%h",
                             want.rd, want.taken, want.halted, want.mode);
                    $display("         act: read_data=%h taken=%b halted=%b mode=%h",
                             rd, taken, hlt, mode);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [3:0]  reg_index;
    logic        use_current_mode;
    logic [4:0]  access_mode;
    logic [31:0] write_data;
    logic        irq_line;
    logic        halt_value;
    logic        done;
    logic [31:0] read_data;
    logic        interrupt_taken;
    logic        halted_now;
    logic [4:0]  mode_now;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    regfile_scoreboard sb;
    int                sender_idle_pct;
    int                idle_cycles;
    int                base_settings;

    arm_banked_register_file u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .reg_index        (reg_index),
        .use_current_mode (use_current_mode),
        .access_mode      (access_mode),
        .write_data       (write_data),
        .irq_line         (irq_line),
        .halt_value       (halt_value),
        .done             (done),
        .read_data        (read_data),
        .interrupt_taken  (interrupt_taken),
        .halted_now       (halted_now),
        .mode_now         (mode_now),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_data, interrupt_taken, halted_now, mode_now);
    end

    // watchdog on cycles without any accepted transaction or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // send one command transaction, with random sender gaps in front
    task automatic issue(op_t op, logic [3:0] r, logic own_mode, logic [4:0] named_mode,
                         logic [31:0] data, logic irq, logic halt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        operation        <= op;
        reg_index        <= r;
        use_current_mode <= own_mode;
        access_mode      <= named_mode;
        write_data       <= data;
        irq_line         <= irq;
        halt_value       <= halt;
        start            <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_command(op, r, own_mode, named_mode, data, irq, halt);
    endtask

    // apb write of the vector base, only while no transaction is in flight
    task automatic write_vector_base(logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_EXC_BASE, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.vector_base = value;
        base_settings++;
    endtask

    // wait until every expected result has come back
    task automatic wait_drained();
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_mode();
        case ($urandom_range(9))
            0:       return MODE_USR;
            1:       return MODE_FIQ;
            2:       return MODE_IRQ;
            3:       return MODE_SVC;
            4:       return MODE_ABT;
            5:       return MODE_UND;
            6:       return MODE_SYS;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    // random command, biased toward banked registers and irq entry
    task automatic random_command();
        op_t         op;
        logic [3:0]  r;
        logic [31:0] data;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 25)      op = OP_READ_REG;
        else if (pick < 45) op = OP_WRITE_REG;
        else if (pick < 52) op = OP_READ_CPSR;
        else if (pick < 62) op = OP_WRITE_CPSR;
        else if (pick < 70) op = OP_READ_SPSR;
        else if (pick < 78) op = OP_WRITE_SPSR;
        else if (pick < 92) op = OP_IRQ_CHECK;
        else                op = OP_SET_HALT;
        r    = $urandom_range(1) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(15));
        data = $urandom;
        // mostly a sane cpsr with a mode that is usually a real one and irq often unmasked
        if (op == OP_WRITE_CPSR && $urandom_range(9) < 8)
        begin
            data[4:0]   = pick_mode();
            data[BIT_I] = ($urandom_range(9) < 3);
        end
        issue(op, r, 1'($urandom_range(1)), pick_mode(), data,
              $urandom_range(3) != 0, 1'($urandom_range(1)));
    endtask

    initial
    begin
        sb               = new();
        sender_idle_pct  = 24;
        base_settings    = 0;
        idle_cycles      <= 0;
        rst_n            <= 1'b0;
        start            <= 1'b0;
        operation        <= OP_READ_REG;
        reg_index        <= '0;
        use_current_mode <= 1'b0;
        access_mode      <= '0;
        write_data       <= '0;
        irq_line         <= 1'b0;
        halt_value       <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // vector base that wraps past zero on irq entry
        write_vector_base(32'hFFFF_FFE8);

        // reset cpsr, pc offset with wrap, fiq and unknown-mode banking
        issue(OP_READ_CPSR,  4'd0,  1'b1, 5'h00,    32'h0,         1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd0,  1'b1, 5'h00,    32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(OP_READ_REG,   4'd0,  1'b0, MODE_FIQ, 32'h0,         1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd15, 1'b1, 5'h00,    32'hFFFF_FFFC, 1'b0, 1'b0);
        issue(OP_READ_REG,   4'd15, 1'b0, MODE_FIQ, 32'h0,         1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd8,  1'b0, MODE_FIQ, 32'hA5A5_5A5A, 1'b0, 1'b0);
        issue(OP_READ_REG,   4'd8,  1'b0, MODE_USR, 32'h0,         1'b0, 1'b0);
        issue(OP_READ_REG,   4'd8,  1'b0, MODE_FIQ, 32'h0,         1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd13, 1'b1, 5'h00,    32'h1234_5678, 1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd14, 1'b0, 5'h00,    32'hDEAD_BEEF, 1'b0, 1'b0);
        issue(OP_READ_REG,   4'd14, 1'b0, MODE_USR, 32'h0,         1'b0, 1'b0);
        issue(OP_READ_REG,   4'd14, 1'b0, 5'h1e,    32'h0,         1'b0, 1'b0);
        // spsr: sys and unknown modes share the user slot
        issue(OP_WRITE_SPSR, 4'd0,  1'b0, MODE_SYS, 32'h0F0F_0F0F, 1'b0, 1'b0);
        issue(OP_READ_SPSR,  4'd0,  1'b0, 5'h07,    32'h0,         1'b0, 1'b0);
        issue(OP_WRITE_SPSR, 4'd0,  1'b1, 5'h00,    32'hFFFF_FFFF, 1'b0, 1'b0);
        // halted, masked irq ignored, then thumb irq entry
        issue(OP_SET_HALT,   4'd0,  1'b1, 5'h00,    32'h0,         1'b0, 1'b1);
        issue(OP_IRQ_CHECK,  4'd0,  1'b1, 5'h00,    32'h0,         1'b1, 1'b0);
        issue(OP_WRITE_CPSR, 4'd0,  1'b1, 5'h00,    32'h0000_0030, 1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd15, 1'b1, 5'h00,    32'h0000_1000, 1'b0, 1'b0);
        issue(OP_IRQ_CHECK,  4'd0,  1'b1, 5'h00,    32'h0,         1'b0, 1'b0);
        issue(OP_IRQ_CHECK,  4'd0,  1'b1, 5'h00,    32'h0,         1'b1, 1'b0);
        issue(OP_READ_REG,   4'd14, 1'b1, 5'h00,    32'h0,         1'b0, 1'b0);
        issue(OP_READ_SPSR,  4'd0,  1'b1, 5'h00,    32'h0,         1'b0, 1'b0);
        // arm irq entry from pc zero, lr wraps below zero
        issue(OP_WRITE_CPSR, 4'd0,  1'b1, 5'h00,    32'hFFFF_FF5F, 1'b0, 1'b0);
        issue(OP_WRITE_REG,  4'd15, 1'b1, 5'h00,    32'hFFFF_FFF8, 1'b0, 1'b0);
        issue(OP_IRQ_CHECK,  4'd0,  1'b0, 5'h00,    32'h0,         1'b1, 1'b0);
        issue(OP_READ_REG,   4'd14, 1'b0, MODE_IRQ, 32'h0,         1'b0, 1'b0);
        start <= 1'b0;
        wait_drained();

        // random phases under different sender gaps and vector bases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 24;
                    write_vector_base(32'hFFFF_FFFF);
                end
                1:
                begin
                    sender_idle_pct = 51;
                    write_vector_base($urandom);
                end
                default:
                begin
                    sender_idle_pct = 0;
                    write_vector_base(32'h0000_0000);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_command();
                // hold off until the block has returned everything
                if (phase == 1 && n == PHASE_ITEMS / 2)
                begin
                    start <= 1'b0;
                    wait_drained();
                end
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d transactions including %0d irq entries", sb.commands,
                 sb.irq_entries);
        $display("across %0d vector base settings, %0d mismatches", base_settings,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
